// File: rtl/btd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btd_pkg
// Shared types, register indexes and defaults of the button tap/hold detector.
// ----------------------------------------------------------------------------
package btd_pkg;

   // fixed widths of the register file and the button masks
   localparam int TIME_W    = 16;
   localparam int COUNT_W   = 4;
   localparam int MASK_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int LANE_LIMIT = 8;

   // parameter defaults
   localparam int BUTTONS_DEF = 8;
   localparam int TICK_MS_DEF = 10;

   // register reset values
   localparam logic [TIME_W-1:0]  TAP_TIME_RST     = 16'd70;
   localparam logic [TIME_W-1:0]  HOLD_TIME_RST    = 16'd1000;
   localparam logic [TIME_W-1:0]  MARGIN_TIME_RST  = 16'd20;
   localparam logic [COUNT_W-1:0] ACTIVE_COUNT_RST = 4'd8;

   // counter ceiling
   localparam logic [TIME_W-1:0] CNT_MAX = 16'hFFFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_TIME     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN_TIME  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COUNT = 2'd3;

   // timing thresholds seen by every lane
   typedef struct packed {
      logic [TIME_W-1:0] tap_time;
      logic [TIME_W-1:0] hold_time;
      logic [TIME_W-1:0] margin_time;
   } btd_cfg_type;

   // per-lane step control
   typedef struct packed {
      logic step;      // a tick is processed this cycle for this lane
      logic pressed;   // sampled level of the button
   } btd_lane_ctl_type;

endpackage : btd_pkg
`default_nettype wire

// File: rtl/btd_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btd_lane
// Pressed and released time counters of one button, with tap and hold events.
// ----------------------------------------------------------------------------
module btd_lane
   import btd_pkg::*;
#(
   parameter int TICK_MS = TICK_MS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire btd_cfg_type      cfg,
   input  wire btd_lane_ctl_type ctl,
   output logic                  tap,
   output logic                  hold
);

   localparam logic [TIME_W:0] TICK = (TIME_W+1)'(TICK_MS);

   logic [TIME_W-1:0] pressed_ms_ff, pressed_ms_in;
   logic [TIME_W-1:0] released_ms_ff, released_ms_in;
   logic [TIME_W:0]   p_sum;
   logic [TIME_W:0]   r_sum;
   logic [TIME_W-1:0] p_sat;

   // counter update for one tick
   always_comb begin
      p_sum = {1'b0, pressed_ms_ff} + TICK;
      r_sum = {1'b0, released_ms_ff} + TICK;
      p_sat = p_sum[TIME_W] ? CNT_MAX : p_sum[TIME_W-1:0];
      pressed_ms_in  = pressed_ms_ff;
      released_ms_in = released_ms_ff;
      tap  = 1'b0;
      hold = 1'b0;
      if (ctl.step) begin
         if (ctl.pressed) begin
            pressed_ms_in = p_sat;
            if (p_sat > cfg.hold_time && released_ms_ff == cfg.margin_time) begin
               hold           = 1'b1;
               released_ms_in = '0;
            end
         end else begin
            if (r_sum >= {1'b0, cfg.margin_time}) begin
               released_ms_in = cfg.margin_time;
               pressed_ms_in  = '0;
               tap = (pressed_ms_ff >= cfg.tap_time) && (pressed_ms_ff <= cfg.hold_time);
            end else begin
               released_ms_in = r_sum[TIME_W-1:0];
            end
         end
      end
   end

   // counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ms_ff  <= '0;
         released_ms_ff <= '0;
      end else begin
         pressed_ms_ff  <= pressed_ms_in;
         released_ms_ff <= released_ms_in;
      end
   end

endmodule : btd_lane
`default_nettype wire

// File: rtl/button_tap_hold_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_tap_hold_detector
// Per-button tap and long-press detection on a stream of scan ticks.
// ----------------------------------------------------------------------------
// path: a tick is captured in the input register, then its counter update is
//   written into the result register, which holds while its result is not taken
// throughput: one tick per cycle while the result slot is free or being taken
// reset: counters cleared, registers at defaults, both stages empty
// ----------------------------------------------------------------------------
module button_tap_hold_detector
   import btd_pkg::*;
#(
   parameter int BUTTONS = BUTTONS_DEF,
   parameter int TICK_MS = TICK_MS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // tick channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [MASK_W-1:0]    req_pressed_mask,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [MASK_W-1:0]         rsp_tap_mask,
   output logic [MASK_W-1:0]         rsp_hold_mask,
   // register write channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIME_W-1:0]    csr_wdata
);

   localparam int LANES = (BUTTONS < LANE_LIMIT) ? BUTTONS : LANE_LIMIT;

   btd_cfg_type        cfg_ff;
   logic [COUNT_W-1:0] active_count_ff;
   logic               in_valid_ff;
   logic [MASK_W-1:0]  in_mask_ff;
   logic               rsp_valid_ff;
   logic [MASK_W-1:0]  rsp_tap_mask_ff, rsp_tap_mask_in;
   logic [MASK_W-1:0]  rsp_hold_mask_ff, rsp_hold_mask_in;
   logic               advance;
   logic [LANES-1:0]   lane_tap;
   logic [LANES-1:0]   lane_hold;

   // register file writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_time    <= TAP_TIME_RST;
         cfg_ff.hold_time   <= HOLD_TIME_RST;
         cfg_ff.margin_time <= MARGIN_TIME_RST;
         active_count_ff    <= ACTIVE_COUNT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TAP_TIME:     cfg_ff.tap_time    <= csr_wdata;
            CSR_HOLD_TIME:    cfg_ff.hold_time   <= csr_wdata;
            CSR_MARGIN_TIME:  cfg_ff.margin_time <= csr_wdata;
            CSR_ACTIVE_COUNT: active_count_ff    <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // stage flow control: compute stage moves when the result slot frees up
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mask_ff <= req_pressed_mask;
      end
   end

   // button lanes
   always_comb begin
      rsp_tap_mask_in  = '0;
      rsp_hold_mask_in = '0;
      rsp_tap_mask_in[LANES-1:0]  = lane_tap;
      rsp_hold_mask_in[LANES-1:0] = lane_hold;
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      btd_lane_ctl_type ctl;

      assign ctl.step    = in_valid_ff && advance &&
                           (COUNT_W'(i) < active_count_ff);
      assign ctl.pressed = in_mask_ff[i];

      btd_lane #(
         .TICK_MS (TICK_MS)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .cfg   (cfg_ff),
         .ctl   (ctl),
         .tap   (lane_tap[i]),
         .hold  (lane_hold[i])
      );
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_tap_mask_ff  <= rsp_tap_mask_in;
         rsp_hold_mask_ff <= rsp_hold_mask_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tap_mask  = rsp_tap_mask_ff;
   assign rsp_hold_mask = rsp_hold_mask_ff;

endmodule : button_tap_hold_detector
`default_nettype wire
